FILE: design/e2u_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the march-based month table for the epoch to utc date pipeline
// no dependencies

package e2u_pkg;

    // stage counts of the two halves of the pipeline
    localparam int DIV_LAT = 4;
    localparam int CIV_LAT = 8;
    localparam int TOTAL_LAT = DIV_LAT + CIV_LAT;
    // time of day finishes early and waits in delay stages
    localparam int TOD_CALC = 3;
    localparam int TOD_PAD = CIV_LAT - TOD_CALC;

    // days from 0000-03-01 to 1970-01-01
    localparam logic [23:0] EPOCH_SHIFT = 24'd719468;

    // seconds per day = 128 * 675
    localparam logic [31:0] DAY_ODD = 32'd675;

    // reciprocal multipliers: floor(x / d) = (x * m) >> k, m = ceil(2^k / d)
    localparam logic [63:0] K_HI = 64'd26;
    localparam logic [63:0] M_HI = ((64'd1 << 26) + 64'd674) / 64'd675;
    localparam logic [63:0] M_LO = ((64'd1 << 37) + 64'd674) / 64'd675;
    localparam logic [63:0] M_ERA = ((64'd1 << 42) + 64'd146096) / 64'd146097;
    localparam logic [63:0] M_HOUR = ((64'd1 << 29) + 64'd3599) / 64'd3600;
    localparam logic [63:0] M_MIN = ((64'd1 << 18) + 64'd59) / 64'd60;
    localparam logic [63:0] M_D1460 = ((64'd1 << 29) + 64'd1459) / 64'd1460;
    localparam logic [63:0] M_D36524 = ((64'd1 << 34) + 64'd36523) / 64'd36524;
    localparam logic [63:0] M_D146096 = ((64'd1 << 36) + 64'd146095) / 64'd146096;
    localparam logic [63:0] M_D365 = ((64'd1 << 27) + 64'd364) / 64'd365;
    localparam logic [63:0] M_D100 = ((64'd1 << 16) + 64'd99) / 64'd100;
    localparam logic [63:0] M_D153 = ((64'd1 << 19) + 64'd152) / 64'd153;

    // day count and second of day handed from the divider to the date and clock stages
    typedef struct packed {
        logic        neg;
        logic [23:0] z;
        logic [16:0] sod;
    } e2u_days_t;

    // first day of each month in a year that starts on march 1
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] r;
        case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: design/epoch_seconds_to_utc_date.sv
`timescale 1ns / 1ps
// top level: unix seconds to utc calendar date and time of day
// depends on e2u_pkg, e2u_divday, e2u_civil, e2u_tod

// Converts a signed 41-bit count of seconds since 1970-01-01 UTC into the
// Gregorian year, month, day, hour, minute and second. The block is a
// 12-stage pipeline: a request can be taken every cycle while the output is
// not stalled. Four stages split the day number off by reciprocal
// multiplication, eight more find the year, month and day while the time
// of day runs alongside. A stall on the output freezes the whole pipeline,
// so the input is stalled exactly while a result waits. A negative
// timestamp gives valid_res low and all other fields zero.

module epoch_seconds_to_utc_date (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [40:0] timestamp,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        valid_res,
    output logic [15:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second
);

    logic                          en;
    logic [e2u_pkg::TOTAL_LAT-1:0] vld_reg;
    logic [e2u_pkg::TOTAL_LAT-1:0] vld_next;
    e2u_pkg::e2u_days_t            days;

    // pipeline moves unless a finished result is held
    assign en = !(vld_reg[e2u_pkg::TOTAL_LAT-1] && out_stall);
    assign in_stall = !en;
    assign out_valid = vld_reg[e2u_pkg::TOTAL_LAT-1];

    // valid bits travel with the data
    assign vld_next = {vld_reg[e2u_pkg::TOTAL_LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    e2u_divday u_divday (
        .clk       (clk),
        .en        (en),
        .timestamp (timestamp),
        .days_out  (days)
    );

    e2u_civil u_civil (
        .clk       (clk),
        .en        (en),
        .days_in   (days),
        .valid_res (valid_res),
        .year      (year),
        .month     (month),
        .day       (day)
    );

    e2u_tod u_tod (
        .clk     (clk),
        .en      (en),
        .days_in (days),
        .hour    (hour),
        .minute  (minute),
        .second  (second)
    );

endmodule

FILE: design/e2u_divday.sv
`timescale 1ns / 1ps
// four-stage split of a timestamp into day number and second of day
// depends on e2u_pkg

module e2u_divday (
    input  logic                clk,
    input  logic                en,
    input  logic [40:0]         timestamp,
    output e2u_pkg::e2u_days_t  days_out
);

    logic [15:0] hi;
    logic [16:0] lo;
    logic [32:0] p_hi;
    logic [6:0]  qh_next;

    logic        s1_neg_reg;
    logic [15:0] s1_hi_reg;
    logic [16:0] s1_lo_reg;
    logic [6:0]  s1_low7_reg;
    logic [6:0]  s1_qh_reg;

    logic [15:0] rh16;
    logic [26:0] x2_next;

    logic        s2_neg_reg;
    logic [26:0] s2_x2_reg;
    logic [6:0]  s2_qh_reg;
    logic [6:0]  s2_low7_reg;

    logic [54:0] p_lo;
    logic [16:0] q2_next;

    logic        s3_neg_reg;
    logic [26:0] s3_x2_reg;
    logic [16:0] s3_q2_reg;
    logic [6:0]  s3_qh_reg;
    logic [6:0]  s3_low7_reg;

    logic [26:0]        r2w;
    logic [23:0]        days;
    e2u_pkg::e2u_days_t days_next;
    e2u_pkg::e2u_days_t s4_reg;

    // stage 1: upper part of seconds/128 divided by 675
    assign hi = timestamp[39:24];
    assign lo = timestamp[23:7];
    assign p_hi = hi * e2u_pkg::M_HI[16:0];
    assign qh_next = p_hi[32:26];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_neg_reg <= timestamp[40];
            s1_hi_reg <= hi;
            s1_lo_reg <= lo;
            s1_low7_reg <= timestamp[6:0];
            s1_qh_reg <= qh_next;
        end
    end

    // stage 2: remainder of the upper part joined to the lower bits
    assign rh16 = s1_hi_reg - ({9'd0, s1_qh_reg} * 16'(e2u_pkg::DAY_ODD));
    assign x2_next = {rh16[9:0], s1_lo_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_neg_reg <= s1_neg_reg;
            s2_x2_reg <= x2_next;
            s2_qh_reg <= s1_qh_reg;
            s2_low7_reg <= s1_low7_reg;
        end
    end

    // stage 3: lower quotient digit
    assign p_lo = s2_x2_reg * e2u_pkg::M_LO[27:0];
    assign q2_next = p_lo[53:37];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_neg_reg <= s2_neg_reg;
            s3_x2_reg <= s2_x2_reg;
            s3_q2_reg <= q2_next;
            s3_qh_reg <= s2_qh_reg;
            s3_low7_reg <= s2_low7_reg;
        end
    end

    // stage 4: second of day and shifted day number
    assign r2w = s3_x2_reg - ({10'd0, s3_q2_reg} * 27'(e2u_pkg::DAY_ODD));
    assign days = {s3_qh_reg, 17'd0} + {7'd0, s3_q2_reg};

    always_comb
    begin
        days_next.neg = s3_neg_reg;
        days_next.z = days + e2u_pkg::EPOCH_SHIFT;
        days_next.sod = {r2w[9:0], s3_low7_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_reg <= days_next;
        end
    end

    assign days_out = s4_reg;

endmodule

FILE: design/e2u_tod.sv
`timescale 1ns / 1ps
// hour, minute and second from the second of day, delayed to line up with the date
// depends on e2u_pkg

module e2u_tod (
    input  logic               clk,
    input  logic               en,
    input  e2u_pkg::e2u_days_t days_in,
    output logic [4:0]         hour,
    output logic [5:0]         minute,
    output logic [5:0]         second
);

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } tod_t;

    logic [34:0] p_hour;
    logic        s5_neg_reg;
    logic [16:0] s5_sod_reg;
    logic [4:0]  s5_hour_reg;

    logic [16:0] rem17;
    logic        s6_neg_reg;
    logic [11:0] s6_rem_reg;
    logic [4:0]  s6_hour_reg;

    logic [24:0] p_min;
    logic        s7_neg_reg;
    logic [11:0] s7_rem_reg;
    logic [4:0]  s7_hour_reg;
    logic [5:0]  s7_min_reg;

    logic [11:0] sec12;
    tod_t        tod_next;
    tod_t        pad_reg [e2u_pkg::TOD_PAD];

    // hour by reciprocal of 3600
    assign p_hour = days_in.sod * e2u_pkg::M_HOUR[17:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_neg_reg <= days_in.neg;
            s5_sod_reg <= days_in.sod;
            s5_hour_reg <= p_hour[33:29];
        end
    end

    // second of hour
    assign rem17 = s5_sod_reg - ({12'd0, s5_hour_reg} * 17'd3600);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_neg_reg <= s5_neg_reg;
            s6_rem_reg <= rem17[11:0];
            s6_hour_reg <= s5_hour_reg;
        end
    end

    // minute by reciprocal of 60
    assign p_min = s6_rem_reg * e2u_pkg::M_MIN[12:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_neg_reg <= s6_neg_reg;
            s7_rem_reg <= s6_rem_reg;
            s7_hour_reg <= s6_hour_reg;
            s7_min_reg <= p_min[23:18];
        end
    end

    // second of minute, zeroed for a negative timestamp
    assign sec12 = s7_rem_reg - ({6'd0, s7_min_reg} * 12'd60);

    always_comb
    begin
        if (s7_neg_reg)
        begin
            tod_next = '0;
        end
        else
        begin
            tod_next.hour = s7_hour_reg;
            tod_next.minute = s7_min_reg;
            tod_next.second = sec12[5:0];
        end
    end

    // delay line to match the date stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pad_reg[0] <= tod_next;
            for (int i = 1; i < e2u_pkg::TOD_PAD; i++)
            begin
                pad_reg[i] <= pad_reg[i-1];
            end
        end
    end

    assign hour = pad_reg[e2u_pkg::TOD_PAD-1].hour;
    assign minute = pad_reg[e2u_pkg::TOD_PAD-1].minute;
    assign second = pad_reg[e2u_pkg::TOD_PAD-1].second;

endmodule

FILE: design/e2u_civil.sv
`timescale 1ns / 1ps
// eight-stage conversion of a march-based day number into year, month and day
// depends on e2u_pkg

module e2u_civil (
    input  logic               clk,
    input  logic               en,
    input  e2u_pkg::e2u_days_t days_in,
    output logic               valid_res,
    output logic [15:0]        year,
    output logic [3:0]         month,
    output logic [4:0]         day
);

    logic [48:0] p_era;
    logic        s5_neg_reg;
    logic [23:0] s5_z_reg;
    logic [6:0]  s5_era_reg;

    logic [23:0] doe24;
    logic        s6_neg_reg;
    logic [17:0] s6_doe_reg;
    logic [6:0]  s6_era_reg;

    logic [36:0] p_a;
    logic [36:0] p_b;
    logic [36:0] p_c;
    logic        s7_neg_reg;
    logic [17:0] s7_doe_reg;
    logic [6:0]  s7_era_reg;
    logic [6:0]  s7_a_reg;
    logic [1:0]  s7_b_reg;
    logic        s7_c_reg;

    logic [17:0] t_next;
    logic        s8_neg_reg;
    logic [17:0] s8_t_reg;
    logic [17:0] s8_doe_reg;
    logic [6:0]  s8_era_reg;

    logic [36:0] p_yoe;
    logic        s9_neg_reg;
    logic [8:0]  s9_yoe_reg;
    logic [17:0] s9_doe_reg;
    logic [6:0]  s9_era_reg;

    logic [18:0] p_y100;
    logic [17:0] yd;
    logic [17:0] doy18;
    logic [15:0] y_next;
    logic        s10_neg_reg;
    logic [8:0]  s10_doy_reg;
    logic [15:0] s10_y_reg;

    logic [10:0] x153;
    logic [22:0] p_mp;
    logic        s11_neg_reg;
    logic [8:0]  s11_doy_reg;
    logic [15:0] s11_y_reg;
    logic [3:0]  s11_mp_reg;

    logic [8:0]  dom9;
    logic        early;
    logic        valid_reg;
    logic [15:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;

    // 400-year era
    assign p_era = days_in.z * e2u_pkg::M_ERA[24:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_neg_reg <= days_in.neg;
            s5_z_reg <= days_in.z;
            s5_era_reg <= p_era[48:42];
        end
    end

    // day of era
    assign doe24 = s5_z_reg - ({17'd0, s5_era_reg} * 24'd146097);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_neg_reg <= s5_neg_reg;
            s6_doe_reg <= doe24[17:0];
            s6_era_reg <= s5_era_reg;
        end
    end

    // leap day corrections within the era
    assign p_a = s6_doe_reg * e2u_pkg::M_D1460[18:0];
    assign p_b = s6_doe_reg * e2u_pkg::M_D36524[18:0];
    assign p_c = s6_doe_reg * e2u_pkg::M_D146096[18:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_neg_reg <= s6_neg_reg;
            s7_doe_reg <= s6_doe_reg;
            s7_era_reg <= s6_era_reg;
            s7_a_reg <= p_a[35:29];
            s7_b_reg <= p_b[35:34];
            s7_c_reg <= p_c[36];
        end
    end

    // day count on a plain 365-day grid
    assign t_next = s7_doe_reg - {11'd0, s7_a_reg} + {16'd0, s7_b_reg} - {17'd0, s7_c_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s8_neg_reg <= s7_neg_reg;
            s8_t_reg <= t_next;
            s8_doe_reg <= s7_doe_reg;
            s8_era_reg <= s7_era_reg;
        end
    end

    // year of era
    assign p_yoe = s8_t_reg * e2u_pkg::M_D365[18:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s9_neg_reg <= s8_neg_reg;
            s9_yoe_reg <= p_yoe[35:27];
            s9_doe_reg <= s8_doe_reg;
            s9_era_reg <= s8_era_reg;
        end
    end

    // day of year and march-based year
    assign p_y100 = s9_yoe_reg * e2u_pkg::M_D100[9:0];
    assign yd = {9'd0, s9_yoe_reg} * 18'd365;
    assign doy18 = s9_doe_reg - (yd + {11'd0, s9_yoe_reg[8:2]} - {16'd0, p_y100[17:16]});
    assign y_next = ({9'd0, s9_era_reg} * 16'd400) + {7'd0, s9_yoe_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s10_neg_reg <= s9_neg_reg;
            s10_doy_reg <= doy18[8:0];
            s10_y_reg <= y_next;
        end
    end

    // month index counted from march
    assign x153 = ({2'd0, s10_doy_reg} * 11'd5) + 11'd2;
    assign p_mp = x153 * e2u_pkg::M_D153[11:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s11_neg_reg <= s10_neg_reg;
            s11_doy_reg <= s10_doy_reg;
            s11_y_reg <= s10_y_reg;
            s11_mp_reg <= p_mp[22:19];
        end
    end

    // calendar month, day and year; january and february belong to the next year
    assign dom9 = s11_doy_reg - e2u_pkg::month_start(s11_mp_reg) + 9'd1;
    assign early = (s11_mp_reg >= 4'd10);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            valid_reg <= !s11_neg_reg;
            if (s11_neg_reg)
            begin
                year_reg <= '0;
                month_reg <= '0;
                day_reg <= '0;
            end
            else
            begin
                year_reg <= s11_y_reg + {15'd0, early};
                month_reg <= early ? (s11_mp_reg - 4'd9) : (s11_mp_reg + 4'd3);
                day_reg <= dom9[4:0];
            end
        end
    end

    assign valid_res = valid_reg;
    assign year = year_reg;
    assign month = month_reg;
    assign day = day_reg;

endmodule

FILE: design/e2u_checker.sv
`timescale 1ns / 1ps
// port-level checks for the epoch to utc date block, bound to the top level
// depends on epoch_seconds_to_utc_date

module e2u_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [40:0] timestamp,
    input logic        out_valid,
    input logic        out_stall,
    input logic        valid_res,
    input logic [15:0] year,
    input logic [3:0]  month,
    input logic [4:0]  day,
    input logic [4:0]  hour,
    input logic [5:0]  minute,
    input logic [5:0]  second
);

    // a held result stays put: year, month, day and second are checked
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(year) && $stable(month)
            && $stable(day) && $stable(second))
        else $error("held result changed");

    // input is stalled only behind a held result
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output stall");

    // converted dates are in calendar range
    a_date: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && valid_res |-> month >= 4'd1 && month <= 4'd12 && day >= 5'd1
            && year >= 16'd1970)
        else $error("date out of range");

    // time of day in range
    a_tod: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> hour < 5'd24 && minute < 6'd60 && second < 6'd60)
        else $error("time of day out of range");

    // rejected timestamps give all zero fields
    a_neg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res |-> year == 16'd0 && month == 4'd0 && day == 5'd0
            && hour == 5'd0 && minute == 6'd0 && second == 6'd0)
        else $error("negative timestamp gave nonzero fields");

endmodule

bind epoch_seconds_to_utc_date e2u_checker u_e2u_checker (.*);

FILE: tb/date_checker.sv
`timescale 1ns / 1ps
// checker for epoch_seconds_to_utc_date: watches both channels, predicts the civil date
// of every accepted request and compares it with each result; no other dependencies

module date_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [40:0] timestamp,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        valid_res,
    input  logic [15:0] year,
    input  logic [3:0]  month,
    input  logic [4:0]  day,
    input  logic [4:0]  hour,
    input  logic [5:0]  minute,
    input  logic [5:0]  second,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic        ok;
        logic [15:0] yr;
        logic [3:0]  mon;
        logic [4:0]  dom;
        logic [4:0]  hr;
        logic [5:0]  mn;
        logic [5:0]  sc;
    } civil_date_t;

    civil_date_t expected_dates[$];

    function automatic longint fdiv(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic longint leaps_through(longint y);
        return fdiv(y, 4) - fdiv(y, 100) + fdiv(y, 400);
    endfunction

    function automatic bit is_leap(longint y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    // unix seconds to gregorian date and time of day
    function automatic civil_date_t to_civil(logic [40:0] ts);
        civil_date_t r;
        longint secs, days, yr, guess, rem;
        int cum[13];
        int d, m, dom;
        r = '0;
        cum = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};
        if (ts[40])
            return r;
        secs = longint'(ts);
        days = secs / 86400;
        rem = secs % 86400;
        r.hr = 5'(rem / 3600);
        r.mn = 6'((rem % 3600) / 60);
        r.sc = 6'(rem % 60);
        yr = 1970;
        do
        begin
            guess = yr + fdiv(days, 365);
            days = days - ((guess - yr) * 365 + leaps_through(guess - 1)
                           - leaps_through(yr - 1));
            yr = guess;
        end
        while (days < 0 || days >= (is_leap(yr) ? 366 : 365));
        d = int'(days);
        dom = 1;
        // leap day folds onto feb 28 plus one
        if (is_leap(yr) && d > 58)
        begin
            if (d == 59)
                dom = 2;
            d = d - 1;
        end
        m = 11;
        while (m > 0 && d < cum[m])
            m = m - 1;
        r.ok = 1'b1;
        r.yr = 16'(yr);
        r.mon = 4'(m + 1);
        r.dom = 5'(dom + d - cum[m]);
        return r;
    endfunction

    assign pending = expected_dates.size();

    // predict on accepted requests, compare on accepted results
    always @(posedge clk or negedge rst_n)
    begin
        civil_date_t want, got;
        if (!rst_n)
        begin
            expected_dates.delete();
            fail_count <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_dates.push_back(to_civil(timestamp));
            if (out_valid && !out_stall)
            begin
                got = '{valid_res, year, month, day, hour, minute, second};
                if (expected_dates.size() == 0)
                begin
                    $display("%0t: unexpected result %p", $time, got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_dates.pop_front();
                    if (want != got)
                    begin
                        $display("%0t: expected %p actual %p", $time, want, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// top of the epoch_seconds_to_utc_date testbench: clock, reset, request stimulus, verdict
// depends on epoch_seconds_to_utc_date and date_checker

module testbench;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [40:0] timestamp;
    logic        out_valid;
    logic        out_stall;
    logic        valid_res;
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    int          fail_count;
    int          pending;
    bit          busy_phase;
    logic [40:0] directed[$];

    epoch_seconds_to_utc_date i_dut (.*);

    date_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("testbench NOT OK");
        $finish;
    end

    function automatic bit idle_now();
        return !busy_phase && ($urandom_range(99) < 7);
    endfunction

    // random receiver stall
    always @(negedge clk)
        out_stall <= rst_n ? idle_now() : 1'b0;

    // random timestamp, mostly valid, with focus near day and year edges
    function automatic logic [40:0] random_ts();
        logic [40:0] t;
        longint base;
        case ($urandom_range(5))
            0: t = 41'({$urandom, $urandom});
            1: t = {1'b0, 40'({$urandom, $urandom})};
            2: t = 41'($urandom);
            3:
            begin
                base = longint'($urandom_range(400)) * 86400 * 365;
                t = 41'(base + longint'($urandom_range(200000)) - 100000);
                t[40] = 1'b0;
            end
            4: t = 41'(longint'($urandom_range(30000)) * 86400 + $urandom_range(1) * 86399);
            default: t = {1'b0, 40'($urandom_range(255)) << 32 | 40'($urandom)};
        endcase
        return t;
    endfunction

    task automatic send(logic [40:0] ts);
        while (idle_now())
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        timestamp <= ts;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        int waited;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        timestamp = '0;
        busy_phase = 1'b0;
        directed = '{41'd0, 41'd86399, 41'd86400, 41'd68169599, 41'd68169600,
                     41'd951782399, 41'd951782400, 41'd951868800, 41'd946684799,
                     41'd4107542400, 41'd4107456000, 41'd1709251199,
                     41'h0FFFFFFFFFF, 41'h0FFFFFFFFFE, 41'h10000000000,
                     41'h1FFFFFFFFFF, 41'h15555555555, 41'h0AAAAAAAAAA,
                     41'h0555555555, 41'd2147483647, 41'd253402300799,
                     41'd31535999, 41'd1234567890};
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        foreach (directed[k])
            send(directed[k]);
        for (int n = 0; n < 1550; n++)
        begin
            busy_phase = (n >= 600 && n < 900);
            send(random_ts());
        end
        busy_phase = 1'b0;
        in_valid <= 1'b0;
        waited = 0;
        while (pending != 0 && waited < 100000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (20) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
